// ===== rtl/core/swpj_pkg.sv =====
// shared constants, types and helpers for the stair ways block
// no dependencies
package swpj_pkg;

  localparam int MAX_STEPS   = 1024;
  localparam int COUNT_WIDTH = 64;

  localparam int CFG_W      = 11;
  localparam int STEP_NUM_W = 11;
  localparam int WAYS_W     = 64;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int ADDR_W     = $clog2(MAX_STEPS);
  localparam int POW_W      = STEP_W + CFG_W;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic REG_STAIR_LENGTH = 1'b0;
  localparam logic REG_JUMP_BASE    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic add_one;
    logic add_mem;
    logic read;
    logic adv;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic broken;
    logic past_end;
    logic from_ground;
    logic single_jump;
    logic out_busy;
  } status_t;

  function automatic logic [STEP_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [STEP_W-1:0] r;
    if (v == '0) begin
      r = STEP_W'(1);
    end else if (int'(v) > MAX_STEPS) begin
      r = STEP_W'(MAX_STEPS);
    end else begin
      r = STEP_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/swpj_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module swpj_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/swpj_ctrl.sv =====
// sequencer for one step: walks the powers of the base, one history read each but the jump from the ground
// depends on swpj_pkg
module swpj_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  swpj_pkg::status_t st,
  output swpj_pkg::cmd_t    cmd
);

  swpj_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swpj_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      swpj_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = swpj_pkg::ST_TEST;
        end
      end
      swpj_pkg::ST_TEST: begin
        if (st.broken || st.past_end) begin
          state_next = swpj_pkg::ST_DONE;
        end else if (st.from_ground) begin
          cmd.add_one = 1'b1;
          cmd.adv     = 1'b1;
          state_next  = st.single_jump ? swpj_pkg::ST_DONE : swpj_pkg::ST_TEST;
        end else begin
          cmd.read   = 1'b1;
          state_next = swpj_pkg::ST_ACC;
        end
      end
      swpj_pkg::ST_ACC: begin
        cmd.add_mem = 1'b1;
        cmd.adv     = 1'b1;
        state_next  = st.single_jump ? swpj_pkg::ST_DONE : swpj_pkg::ST_TEST;
      end
      swpj_pkg::ST_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = swpj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swpj_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/swpj_dp.sv =====
// datapath: step counter, power register, saturating accumulator, history ram,
// result register; depends on swpj_pkg and swpj_ram
module swpj_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  swpj_pkg::cmd_t                   cmd,
  output swpj_pkg::status_t                st,
  input  logic                             item_broken,
  input  logic [swpj_pkg::CFG_W-1:0]       stair_length,
  input  logic [swpj_pkg::CFG_W-1:0]       jump_base,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [swpj_pkg::WAYS_W-1:0]      ways,
  output logic [swpj_pkg::STEP_NUM_W-1:0]  step_number,
  output logic                             saturated,
  output logic                             last_step
);

  logic [swpj_pkg::STEP_W-1:0]      step_counter;
  logic [swpj_pkg::STEP_W-1:0]      j;
  logic [swpj_pkg::STEP_W-1:0]      len;
  logic                             broken_q;
  logic [swpj_pkg::POW_W-1:0]       pow;
  logic [swpj_pkg::COUNT_WIDTH-1:0] acc;
  logic                             over;

  logic [swpj_pkg::STEP_W-1:0]      j_next;
  logic [swpj_pkg::STEP_W-1:0]      from;
  logic [swpj_pkg::COUNT_WIDTH-1:0] addend;
  logic [swpj_pkg::COUNT_WIDTH:0]   sum;
  logic [swpj_pkg::COUNT_WIDTH-1:0] rd_data;
  logic                             last;

  assign j_next = (int'(step_counter) + 1 > swpj_pkg::MAX_STEPS)
                  ? swpj_pkg::STEP_W'(swpj_pkg::MAX_STEPS)
                  : step_counter + swpj_pkg::STEP_W'(1);

  assign from   = j - pow[swpj_pkg::STEP_W-1:0];
  assign addend = cmd.add_mem ? rd_data : swpj_pkg::COUNT_WIDTH'(1);
  assign sum    = {1'b0, acc} + {1'b0, addend};
  assign last   = (j >= len);

  assign st.broken      = broken_q;
  assign st.past_end    = (pow > swpj_pkg::POW_W'(j));
  assign st.from_ground = (from == '0);
  assign st.single_jump = (jump_base < swpj_pkg::CFG_W'(2));
  assign st.out_busy    = result_valid && result_stall;

  swpj_ram #(
    .WIDTH(swpj_pkg::COUNT_WIDTH),
    .DEPTH(swpj_pkg::MAX_STEPS)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.finish),
    .waddr(swpj_pkg::ADDR_W'(j - swpj_pkg::STEP_W'(1))),
    .wdata(acc),
    .re   (cmd.read),
    .raddr(swpj_pkg::ADDR_W'(from - swpj_pkg::STEP_W'(1))),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      j        <= j_next;
      len      <= swpj_pkg::clamp_len(stair_length);
      broken_q <= item_broken;
      pow      <= swpj_pkg::POW_W'(1);
      acc      <= '0;
      over     <= 1'b0;
    end else begin
      if (cmd.add_one || cmd.add_mem) begin
        if (sum[swpj_pkg::COUNT_WIDTH]) begin
          acc  <= '1;
          over <= 1'b1;
        end else begin
          acc <= sum[swpj_pkg::COUNT_WIDTH-1:0];
        end
      end
      if (cmd.adv) begin
        pow <= swpj_pkg::POW_W'(pow * jump_base);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        step_counter <= last ? '0 : j;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ways        <= swpj_pkg::WAYS_W'(acc);
      step_number <= swpj_pkg::STEP_NUM_W'(j);
      saturated   <= over;
      last_step   <= last;
    end
  end

endmodule

// ===== rtl/core/stair_ways_power_jumps.sv =====
// Counts the ways to climb a stair whose jumps are powers of jump_base, one
// step per item with a broken flag, and returns one result per item: the
// saturated count, the step number, a saturation flag and a last mark at
// stair_length. Each power of jump_base not above the step number costs one
// read of the count history memory and one add, but the jump landing on the
// ground costs only an add. A broken step skips the powers and goes straight
// to its result. The next item is taken while the previous result waits in
// the output register.
// depends on swpj_pkg, swpj_ctrl, swpj_dp
module stair_ways_power_jumps (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swpj_pkg::PADDR_W-1:0]        paddr,
  input  logic [swpj_pkg::PDATA_W-1:0]        pwdata,
  output logic [swpj_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                broken,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [swpj_pkg::WAYS_W-1:0]         ways,
  output logic [swpj_pkg::STEP_NUM_W-1:0]     step_number,
  output logic                                saturated,
  output logic                                last_step
);

  logic [swpj_pkg::CFG_W-1:0] stair_length;
  logic [swpj_pkg::CFG_W-1:0] jump_base;
  logic                       reg_sel;
  logic                       wr_en;
  swpj_pkg::cmd_t             cmd;
  swpj_pkg::status_t          st;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stair_length <= swpj_pkg::CFG_W'(30);
      jump_base    <= swpj_pkg::CFG_W'(2);
    end else if (wr_en) begin
      unique case (reg_sel)
        swpj_pkg::REG_STAIR_LENGTH: stair_length <= pwdata[swpj_pkg::CFG_W-1:0];
        swpj_pkg::REG_JUMP_BASE:    jump_base    <= pwdata[swpj_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      swpj_pkg::REG_STAIR_LENGTH: prdata = swpj_pkg::PDATA_W'(stair_length);
      swpj_pkg::REG_JUMP_BASE:    prdata = swpj_pkg::PDATA_W'(jump_base);
      default:                    prdata = '0;
    endcase
  end

  swpj_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .st        (st),
    .cmd       (cmd)
  );

  swpj_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .item_broken (broken),
    .stair_length(stair_length),
    .jump_base   (jump_base),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .ways        (ways),
    .step_number (step_number),
    .saturated   (saturated),
    .last_step   (last_step)
  );

endmodule
